[src/bsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

  // Field widths of the channels.
  localparam int RAW_TEMP_W = 16;
  localparam int RAW_PRES_W = 24;
  localparam int TEMP_W     = 16;
  localparam int PRES_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MC_MD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OSS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_CNT  = 3'd6;

  // Compensation constants.
  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [15:0] B7_SCALE  = 16'd50000;
  localparam logic [16:0] P_K1      = 17'd3038;
  localparam logic [16:0] P_K2      = 17'd7357;
  localparam logic [31:0] P_K3      = 32'd3791;
  localparam logic [31:0] B4_BIAS   = 32'd32768;

endpackage
`default_nettype wire

[src/bsc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Raw sample channel.
interface bsc_sample_if import bsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RAW_TEMP_W-1:0] raw_temp;
  logic [RAW_PRES_W-1:0] raw_pressure;
  modport source (output valid, raw_temp, raw_pressure, input ready);
  modport sink   (input valid, raw_temp, raw_pressure, output ready);
endinterface

// Compensated result channel.
interface bsc_result_if import bsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic        [PRES_W-1:0] pressure;
  logic                     window_done;
  logic signed [TEMP_W-1:0] mean_temperature;
  logic        [PRES_W-1:0] mean_pressure;
  logic                     divide_error;
  modport source (output valid, temperature, pressure, window_done, mean_temperature,
                  mean_pressure, divide_error, input ready);
  modport sink   (input valid, temperature, pressure, window_done, mean_temperature,
                  mean_pressure, divide_error, output ready);
endinterface

// Register write channel.
interface bsc_cfg_if import bsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/baro_sensor_compensation_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Role  Payload
// sample   sink  raw_temp, raw_pressure
// result   src   temperature, pressure, window_done, mean_temperature,
//                mean_pressure, divide_error
// cfg      sink  index, data (always ready)
//
// An item passes through the sequencer states and is then handed to the output
// register; an item that closes an averaging window also runs the two window-mean
// divisions, and a division is skipped when its divisor is zero. The pace is set by
// the radix-2 divider (32 iterations per division, two divisions per item and two
// more for the window means) and by the single shared multiplier.
// A new item is taken only once the previous one has been handed to the output
// register; a stalled result holds the block before its next item.
// Synchronous reset clears the sequencer, window sums, config registers and o_valid.
module baro_sensor_compensation_top import bsc_pkg::*; #(
  parameter int MAX_AVERAGE = 16
) (
  input  wire        clk,
  input  wire        rst,
  bsc_sample_if.sink   sample,
  bsc_result_if.source result,
  bsc_cfg_if.sink      cfg
);

  localparam int CNT_W  = $clog2(MAX_AVERAGE + 1);
  localparam int TSUM_W = 17 + $clog2(MAX_AVERAGE);
  localparam int PSUM_W = 18 + $clog2(MAX_AVERAGE);

  // Sequencer states.
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_T_MUL    = 5'd1;
  localparam logic [4:0] S_T_X1     = 5'd2;
  localparam logic [4:0] S_T_DIV    = 5'd3;
  localparam logic [4:0] S_T_X2     = 5'd4;
  localparam logic [4:0] S_T_B5     = 5'd5;
  localparam logic [4:0] S_T_B6     = 5'd6;
  localparam logic [4:0] S_P_SQ_LO  = 5'd7;
  localparam logic [4:0] S_P_SQ_HI  = 5'd8;
  localparam logic [4:0] S_P_B6SQ   = 5'd9;
  localparam logic [4:0] S_P_X2     = 5'd10;
  localparam logic [4:0] S_P_X3     = 5'd11;
  localparam logic [4:0] S_P_B3     = 5'd12;
  localparam logic [4:0] S_P_XU     = 5'd13;
  localparam logic [4:0] S_P_B4M    = 5'd14;
  localparam logic [4:0] S_P_B4     = 5'd15;
  localparam logic [4:0] S_P_B7     = 5'd16;
  localparam logic [4:0] S_P_DIV    = 5'd17;
  localparam logic [4:0] S_P_PU     = 5'd18;
  localparam logic [4:0] S_P_SQ2_LO = 5'd19;
  localparam logic [4:0] S_P_SQ2_HI = 5'd20;
  localparam logic [4:0] S_P_C1     = 5'd21;
  localparam logic [4:0] S_P_C2     = 5'd22;
  localparam logic [4:0] S_P_FIN    = 5'd23;
  localparam logic [4:0] S_M_T      = 5'd24;
  localparam logic [4:0] S_M_P      = 5'd25;
  localparam logic [4:0] S_DONE     = 5'd26;

  logic [4:0] state;

  // Configuration registers.
  logic [31:0] coef_ac1_ac2, coef_ac3_ac4, coef_ac5_ac6, coef_b1_b2, coef_mc_md;
  logic [1:0]  oss;
  logic [4:0]  avg_cnt;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ac1_ac2 <= '0;
      coef_ac3_ac4 <= '0;
      coef_ac5_ac6 <= '0;
      coef_b1_b2   <= '0;
      coef_mc_md   <= '0;
      oss          <= '0;
      avg_cnt      <= 5'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_AC1_AC2: coef_ac1_ac2 <= cfg.data;
        REG_AC3_AC4: coef_ac3_ac4 <= cfg.data;
        REG_AC5_AC6: coef_ac5_ac6 <= cfg.data;
        REG_B1_B2:   coef_b1_b2   <= cfg.data;
        REG_MC_MD:   coef_mc_md   <= cfg.data;
        REG_OSS:     oss          <= cfg.data[1:0];
        REG_AVG_CNT: avg_cnt      <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // Coefficient fields.
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;
  assign ac1 = $signed(coef_ac1_ac2[31:16]);
  assign ac2 = $signed(coef_ac1_ac2[15:0]);
  assign ac3 = $signed(coef_ac3_ac4[31:16]);
  assign ac4 = coef_ac3_ac4[15:0];
  assign ac5 = coef_ac5_ac6[31:16];
  assign ac6 = coef_ac5_ac6[15:0];
  assign b1  = $signed(coef_b1_b2[31:16]);
  assign b2  = $signed(coef_b1_b2[15:0]);
  assign mc  = $signed(coef_mc_md[31:16]);
  assign md  = $signed(coef_mc_md[15:0]);

  // Effective window length, clamped to one and to the largest window.
  logic [9:0] win_len;
  always_comb begin
    if (avg_cnt == 5'd0) begin
      win_len = 10'd1;
    end else if (10'(avg_cnt) > 10'(MAX_AVERAGE)) begin
      win_len = 10'(MAX_AVERAGE);
    end else begin
      win_len = 10'(avg_cnt);
    end
  end

  // Working registers.
  logic [15:0]        ut_r;
  logic [23:0]        up_r;
  logic signed [17:0] x1;
  logic signed [27:0] x2;
  logic               x2_neg;
  logic signed [28:0] b5;
  logic signed [29:0] b6;
  logic signed [47:0] b6sq;
  logic signed [35:0] xa;
  logic signed [52:0] x3;
  logic [31:0]        b3lo;
  logic signed [33:0] t1;
  logic [31:0]        xu;
  logic [16:0]        b4;
  logic [31:0]        b7;
  logic [31:0]        pu;
  logic signed [43:0] x1p;
  logic               derr;
  logic signed [15:0] tsat;
  logic [17:0]        psat;
  logic               wdone;
  logic signed [15:0] mtemp;
  logic [17:0]        mpres;
  logic               tneg;

  // Window state.
  logic [CNT_W-1:0]         sample_count;
  logic signed [TSUM_W-1:0] temp_sum;
  logic [PSUM_W-1:0]        pressure_sum;

  // Shared multiply-accumulate unit.
  logic signed [47:0] mul_a;
  logic signed [16:0] mul_b;
  logic               mul_acc, mul_hi;
  logic signed [64:0] mul_full;
  logic signed [63:0] prod;

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= (mul_acc ? prod : 64'sd0)
            + (mul_hi ? (mul_full[63:0] <<< 15) : mul_full[63:0]);
  end

  // Serial restoring divider.
  logic        div_go, div_run;
  logic [31:0] div_num, div_den_in;
  logic [4:0]  div_cnt;
  logic [31:0] div_quo, div_rem, div_den;
  logic [32:0] div_sh, div_diff;

  assign div_sh   = {div_rem, div_quo[31]};
  assign div_diff = div_sh - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_cnt <= '0;
    end else if (div_go) begin
      div_run <= 1'b1;
      div_cnt <= '0;
      div_quo <= div_num;
      div_rem <= '0;
      div_den <= div_den_in;
    end else if (div_run) begin
      if (!div_diff[32]) begin
        div_rem <= div_diff[31:0];
        div_quo <= {div_quo[30:0], 1'b1};
      end else begin
        div_rem <= div_sh[31:0];
        div_quo <= {div_quo[30:0], 1'b0};
      end
      div_cnt <= div_cnt + 5'd1;
      if (div_cnt == 5'd31) begin
        div_run <= 1'b0;
      end
    end
  end

  // Combinational terms used by the sequencer.
  logic signed [16:0] ut_d;
  logic signed [18:0] den_v;
  logic [16:0]        amc;
  logic [18:0]        aden;
  logic signed [29:0] t_rnd;
  logic signed [25:0] tq;
  logic [33:0]        b3_v, b3_w, b3_r, xs;
  logic [31:0]        diff32;
  logic signed [31:0] p_s;
  logic signed [23:0] p8;
  logic signed [31:0] x2p;
  logic signed [45:0] fin_s, pf;
  logic [CNT_W-1:0]   cnt_new;
  logic signed [TSUM_W-1:0] tsum_new;
  logic [PSUM_W-1:0]  psum_new;
  logic [TSUM_W-1:0]  tsum_new_abs;
  logic [17:0]        pf_sat;
  logic               close_win;

  assign ut_d   = $signed({1'b0, ut_r}) - $signed({1'b0, ac6});
  assign den_v  = 19'(x1) + 19'(md);
  assign amc    = mc[15] ? 17'(-17'(mc)) : 17'(mc);
  assign aden   = den_v[18] ? 19'(-den_v) : 19'(den_v);
  assign t_rnd  = 30'(b5) + 30'sd8;
  assign tq     = t_rnd[29:4];
  assign b3_v   = (34'(ac1) << 2) + x3[33:0];
  assign b3_w   = b3_v << oss;
  assign b3_r   = b3_w + 34'd2;
  assign xs     = t1[33:0] + prod[49:16] + 34'd2;
  assign diff32 = 32'(up_r) - b3lo;
  assign p_s    = $signed(pu);
  assign p8     = p_s[31:8];
  assign x2p    = $signed(prod[47:16]);
  assign fin_s  = 46'(x1p) + 46'(x2p) + 46'(P_K3);
  assign pf     = 46'(p_s) + (fin_s >>> 4);

  always_comb begin
    if (pf < 46'sd0) begin
      pf_sat = '0;
    end else if (pf > 46'sd262143) begin
      pf_sat = '1;
    end else begin
      pf_sat = pf[17:0];
    end
  end

  assign cnt_new      = sample_count + CNT_W'(1);
  assign tsum_new     = temp_sum + TSUM_W'(tsat);
  assign psum_new     = pressure_sum + PSUM_W'(pf_sat);
  assign close_win    = 10'(cnt_new) >= win_len;
  assign tsum_new_abs = tsum_new[TSUM_W-1] ? TSUM_W'(-tsum_new) : TSUM_W'(tsum_new);

  // Operand selection for the multiplier and the divider.
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mul_acc    = 1'b0;
    mul_hi     = 1'b0;
    div_go     = 1'b0;
    div_num    = '0;
    div_den_in = '0;
    case (state)
      S_T_MUL: begin
        mul_a = 48'(ut_d);
        mul_b = $signed({1'b0, ac5});
      end
      S_T_DIV: begin
        div_go     = (den_v != 19'sd0);
        div_num    = 32'({amc, 11'd0});
        div_den_in = 32'(aden);
      end
      S_P_SQ_LO: begin
        mul_a = 48'(b6);
        mul_b = $signed({2'b00, b6[14:0]});
      end
      S_P_SQ_HI: begin
        mul_a   = 48'(b6);
        mul_b   = 17'($signed(b6[29:15]));
        mul_acc = 1'b1;
        mul_hi  = 1'b1;
      end
      S_P_B6SQ: begin
        mul_a = 48'(b6);
        mul_b = 17'(ac2);
      end
      S_P_X2: begin
        mul_a = b6sq;
        mul_b = 17'(b2);
      end
      S_P_X3: begin
        mul_a = 48'(b6);
        mul_b = 17'(ac3);
      end
      S_P_B3: begin
        mul_a = b6sq;
        mul_b = 17'(b1);
      end
      S_P_B4M: begin
        mul_a = $signed({16'd0, xu});
        mul_b = $signed({1'b0, ac4});
      end
      S_P_B4: begin
        mul_a = $signed({16'd0, diff32});
        mul_b = $signed({1'b0, B7_SCALE >> oss});
      end
      S_P_DIV: begin
        div_go     = (b4 != 17'd0);
        div_num    = b7[31] ? b7 : {b7[30:0], 1'b0};
        div_den_in = 32'(b4);
      end
      S_P_SQ2_LO: begin
        mul_a = 48'(p8);
        mul_b = $signed({2'b00, p8[14:0]});
      end
      S_P_SQ2_HI: begin
        mul_a   = 48'(p8);
        mul_b   = 17'($signed(p8[23:15]));
        mul_acc = 1'b1;
        mul_hi  = 1'b1;
      end
      S_P_C1: begin
        mul_a = $signed(prod[47:0]);
        mul_b = $signed(P_K1);
      end
      S_P_C2: begin
        mul_a = 48'(p_s);
        mul_b = -$signed(P_K2);
      end
      S_P_FIN: begin
        div_go     = close_win;
        div_num    = 32'(tsum_new_abs);
        div_den_in = 32'(cnt_new);
      end
      S_M_T: begin
        div_go     = !div_run;
        div_num    = 32'(pressure_sum);
        div_den_in = 32'(sample_count);
      end
      default: ;
    endcase
  end

  // Output register.
  logic               o_valid;
  logic signed [15:0] o_temp, o_mtemp;
  logic [17:0]        o_pres, o_mpres;
  logic               o_done, o_derr;

  assign sample.ready            = (state == S_IDLE);
  assign result.valid            = o_valid;
  assign result.temperature      = o_temp;
  assign result.pressure         = o_pres;
  assign result.window_done      = o_done;
  assign result.mean_temperature = o_mtemp;
  assign result.mean_pressure    = o_mpres;
  assign result.divide_error     = o_derr;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      o_valid      <= 1'b0;
      sample_count <= '0;
      temp_sum     <= '0;
      pressure_sum <= '0;
    end else begin
      // The output register empties when its item is taken, unless a new item
      // replaces it in the same cycle.
      if (o_valid && result.ready && state != S_DONE) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            ut_r  <= sample.raw_temp;
            up_r  <= 24'(sample.raw_pressure >> (4'd8 - 4'(oss)));
            derr  <= 1'b0;
            state <= S_T_MUL;
          end
        end
        S_T_MUL: state <= S_T_X1;
        S_T_X1: begin
          x1    <= $signed(prod[32:15]);
          state <= S_T_DIV;
        end
        S_T_DIV: begin
          x2_neg <= mc[15] ^ den_v[18];
          if (den_v == 19'sd0) begin
            x2    <= '0;
            derr  <= 1'b1;
            state <= S_T_B5;
          end else begin
            state <= S_T_X2;
          end
        end
        S_T_X2: begin
          if (!div_run) begin
            x2    <= x2_neg ? 28'(-$signed({1'b0, div_quo[26:0]}))
                            : $signed({1'b0, div_quo[26:0]});
            state <= S_T_B5;
          end
        end
        S_T_B5: begin
          b5    <= 29'(x1) + 29'(x2);
          state <= S_T_B6;
        end
        S_T_B6: begin
          b6 <= 30'(b5) - 30'(B6_OFFSET);
          if (tq > 26'sd32767) begin
            tsat <= 16'sh7fff;
          end else if (tq < -26'sd32768) begin
            tsat <= 16'sh8000;
          end else begin
            tsat <= tq[15:0];
          end
          state <= S_P_SQ_LO;
        end
        S_P_SQ_LO: state <= S_P_SQ_HI;
        S_P_SQ_HI: state <= S_P_B6SQ;
        S_P_B6SQ: begin
          b6sq  <= $signed(prod[59:12]);
          state <= S_P_X2;
        end
        S_P_X2: begin
          xa    <= $signed(prod[46:11]);
          state <= S_P_X3;
        end
        S_P_X3: begin
          x3    <= 53'(xa) + $signed(prod[63:11]);
          state <= S_P_B3;
        end
        S_P_B3: begin
          b3lo  <= b3_r[33:2];
          t1    <= $signed(prod[46:13]);
          state <= S_P_XU;
        end
        S_P_XU: begin
          xu    <= xs[33:2] + B4_BIAS;
          state <= S_P_B4M;
        end
        S_P_B4M: state <= S_P_B4;
        S_P_B4: begin
          b4    <= prod[31:15];
          state <= S_P_B7;
        end
        S_P_B7: begin
          b7    <= prod[31:0];
          state <= S_P_DIV;
        end
        S_P_DIV: begin
          if (b4 == 17'd0) begin
            pu    <= '0;
            derr  <= 1'b1;
            state <= S_P_SQ2_LO;
          end else begin
            state <= S_P_PU;
          end
        end
        S_P_PU: begin
          if (!div_run) begin
            pu    <= b7[31] ? {div_quo[30:0], 1'b0} : div_quo;
            state <= S_P_SQ2_LO;
          end
        end
        S_P_SQ2_LO: state <= S_P_SQ2_HI;
        S_P_SQ2_HI: state <= S_P_C1;
        S_P_C1:     state <= S_P_C2;
        S_P_C2: begin
          x1p   <= $signed(prod[59:16]);
          state <= S_P_FIN;
        end
        S_P_FIN: begin
          psat         <= pf_sat;
          sample_count <= cnt_new;
          temp_sum     <= tsum_new;
          pressure_sum <= psum_new;
          tneg         <= tsum_new[TSUM_W-1];
          wdone        <= close_win;
          mtemp        <= '0;
          mpres        <= '0;
          state        <= close_win ? S_M_T : S_DONE;
        end
        S_M_T: begin
          if (!div_run) begin
            mtemp <= tneg ? 16'(-div_quo[15:0]) : $signed(div_quo[15:0]);
            state <= S_M_P;
          end
        end
        S_M_P: begin
          if (!div_run) begin
            mpres        <= div_quo[17:0];
            sample_count <= '0;
            temp_sum     <= '0;
            pressure_sum <= '0;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!o_valid || result.ready) begin
            o_valid <= 1'b1;
            o_temp  <= tsat;
            o_pres  <= psat;
            o_done  <= wdone;
            o_mtemp <= mtemp;
            o_mpres <= mpres;
            o_derr  <= derr;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and the window bookkeeping.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample taken while an item is in progress");

  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_go |-> !div_run)
    else $error("divider restarted while busy");

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && wdone) |-> (sample_count == '0 && temp_sum == '0))
    else $error("window state not cleared after a closing item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sample_count) < 32'(MAX_AVERAGE) || state == S_M_T || state == S_M_P)
    else $error("window count beyond the largest window");

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import bsc_pkg::*;

  localparam int NUM_RANDOM  = 600;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [RAW_TEMP_W-1:0] raw_temp;
    logic [RAW_PRES_W-1:0] raw_pressure;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic        [PRES_W-1:0] pressure;
    logic                     window_done;
    logic signed [TEMP_W-1:0] mean_temperature;
    logic        [PRES_W-1:0] mean_pressure;
    logic                     divide_error;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsc_sample_if sample_ch ();
  bsc_result_if result_ch ();
  bsc_cfg_if    cfg_ch ();

  baro_sensor_compensation_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch.sink),
    .result (result_ch.source),
    .cfg    (cfg_ch.sink)
  );

  always #1 clk = ~clk;

  // Shadow of the configuration and of the averaging window.
  logic [31:0] sh_ac12, sh_ac34, sh_ac56, sh_b12, sh_mcmd;
  logic [1:0]  sh_oss;
  logic [4:0]  sh_avg;
  int          win_count;
  longint      win_temp_sum, win_pres_sum;

  sample_t pending_samples[$];
  comp_t   expected_results[$];

  int  errors = 0;
  int  accepted = 0;
  int  checked = 0;
  int  windows = 0;
  int  div_errors = 0;
  int  cycles = 0;
  bit  quiet_phase = 0;
  bit  long_hold = 0;
  bit  in_taken = 0;
  int  src_gap = 0;
  int  snk_gap = 0;

  function automatic longint fl_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Compensates one sample and updates the window; returns the expected item.
  function automatic comp_t compensate(sample_t s);
    comp_t  r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, b5, b6, b6sq, b3, den, t, p;
    logic [31:0] b4, b7, pu;
    int     len;
    bit     derr;
    ac1 = longint'($signed(sh_ac12[31:16])); ac2 = longint'($signed(sh_ac12[15:0]));
    ac3 = longint'($signed(sh_ac34[31:16])); ac4 = longint'(sh_ac34[15:0]);
    ac5 = longint'(sh_ac56[31:16]);          ac6 = longint'(sh_ac56[15:0]);
    b1  = longint'($signed(sh_b12[31:16]));  b2  = longint'($signed(sh_b12[15:0]));
    mc  = longint'($signed(sh_mcmd[31:16])); md  = longint'($signed(sh_mcmd[15:0]));
    derr = 0;
    ut = longint'(s.raw_temp);
    up = longint'(s.raw_pressure >> (8 - sh_oss));

    // Temperature.
    x1 = fl_shr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      x2 = 0;
      derr = 1;
    end else begin
      x2 = (mc * 2048) / den;
    end
    b5 = x1 + x2;
    t = fl_shr(b5 + 8, 4);

    // Pressure.
    b6 = b5 - 4000;
    b6sq = fl_shr(b6 * b6, 12);
    x1 = fl_shr(b2 * b6sq, 11);
    x2 = fl_shr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = fl_shr((ac1 * 4 + x3) * (longint'(1) << sh_oss) + 2, 2);
    x1 = fl_shr(ac3 * b6, 13);
    x2 = fl_shr(b1 * b6sq, 16);
    x3 = fl_shr(x1 + x2 + 2, 2);
    b4 = (ac4[31:0] * 32'(x3 + 32768)) >> 15;
    b7 = (up[31:0] - b3[31:0]) * (32'd50000 >> sh_oss);
    if (b4 == 0) begin
      pu = 0;
      derr = 1;
    end else if (b7 < 32'h8000_0000) begin
      pu = (b7 * 2) / b4;
    end else begin
      pu = (b7 / b4) * 2;
    end
    p = longint'($signed(pu));
    x1 = fl_shr(p, 8) * fl_shr(p, 8);
    x1 = fl_shr(x1 * 3038, 16);
    x2 = fl_shr(-7357 * p, 16);
    p = p + fl_shr(x1 + x2 + 3791, 4);

    t = clamp(t, -32768, 32767);
    p = clamp(p, 0, 262143);

    // Window averaging.
    len = int'(sh_avg);
    if (len == 0) len = 1;
    if (len > 16) len = 16;
    win_temp_sum += t;
    win_pres_sum += p;
    win_count++;
    r = '0;
    r.temperature = t[15:0];
    r.pressure = p[17:0];
    r.divide_error = derr;
    if (win_count >= len) begin
      r.window_done = 1'b1;
      r.mean_temperature = 16'(clamp(win_temp_sum / win_count, -32768, 32767));
      r.mean_pressure = 18'(clamp(win_pres_sum / win_count, 0, 262143));
      win_count = 0;
      win_temp_sum = 0;
      win_pres_sum = 0;
    end
    return r;
  endfunction

  // Sample driver: feeds queued items with random gaps, none in the quiet phase.
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (sample_ch.valid && !in_taken) begin
      // Hold the offered item.
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      sample_ch.valid <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      src_gap <= $urandom_range(1, 19);
      sample_ch.valid <= 1'b0;
    end else if (pending_samples.size() > 0) begin
      {sample_ch.raw_temp, sample_ch.raw_pressure} <= pending_samples.pop_front();
      sample_ch.valid <= 1'b1;
    end else begin
      sample_ch.valid <= 1'b0;
    end
  end

  // Result ready: random stalls outside the quiet phase, plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (long_hold) begin
      result_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      result_ch.ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      snk_gap <= $urandom_range(1, 19);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts on accepted samples and checks accepted results.
  always @(posedge clk) begin
    comp_t exp_r;
    cycles <= cycles + 1;
    in_taken <= !rst && sample_ch.valid && sample_ch.ready;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      expected_results.push_back(compensate({sample_ch.raw_temp, sample_ch.raw_pressure}));
      accepted <= accepted + 1;
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item");
        errors <= errors + 1;
      end else begin
        exp_r = expected_results.pop_front();
        checked <= checked + 1;
        if (result_ch.window_done) windows <= windows + 1;
        if (result_ch.divide_error) div_errors <= div_errors + 1;
        if (result_ch.temperature !== exp_r.temperature) begin
          $error("temperature: expected %0d, got %0d", exp_r.temperature,
                 result_ch.temperature);
          errors <= errors + 1;
        end
        if (result_ch.pressure !== exp_r.pressure) begin
          $error("pressure: expected %0d, got %0d", exp_r.pressure, result_ch.pressure);
          errors <= errors + 1;
        end
        if (result_ch.window_done !== exp_r.window_done) begin
          $error("window_done: expected %0d, got %0d", exp_r.window_done,
                 result_ch.window_done);
          errors <= errors + 1;
        end
        if (result_ch.mean_temperature !== exp_r.mean_temperature) begin
          $error("mean_temperature: expected %0d, got %0d", exp_r.mean_temperature,
                 result_ch.mean_temperature);
          errors <= errors + 1;
        end
        if (result_ch.mean_pressure !== exp_r.mean_pressure) begin
          $error("mean_pressure: expected %0d, got %0d", exp_r.mean_pressure,
                 result_ch.mean_pressure);
          errors <= errors + 1;
        end
        if (result_ch.divide_error !== exp_r.divide_error) begin
          $error("divide_error: expected %0d, got %0d", exp_r.divide_error,
                 result_ch.divide_error);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d items outstanding", expected_results.size());
      $display("** baro_sensor_compensation_top: FAILED **");
      $finish;
    end
  end

  // Writes one register; the shadow copy follows at the same edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_AC1_AC2: sh_ac12 = val;
      REG_AC3_AC4: sh_ac34 = val;
      REG_AC5_AC6: sh_ac56 = val;
      REG_B1_B2:   sh_b12  = val;
      REG_MC_MD:   sh_mcmd = val;
      REG_OSS:     sh_oss  = val[1:0];
      REG_AVG_CNT: sh_avg  = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || expected_results.size() > 0 || sample_ch.valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Typical datasheet calibration, with random perturbation when asked.
  task automatic load_coefs(bit perturb);
    logic [15:0] j;
    j = perturb ? 16'($urandom_range(0, 63)) : 16'd0;
    write_reg(REG_AC1_AC2, {16'd408 + j, 16'hFFD2});
    write_reg(REG_AC3_AC4, {16'hC7A5 - j, 16'd32741 + j});
    write_reg(REG_AC5_AC6, {16'd32757 - j, 16'd23153 + j});
    write_reg(REG_B1_B2,   {16'd6190 + j, 16'd4});
    write_reg(REG_MC_MD,   {16'hD4BD - j, 16'd2868 + j});
  endtask

  // Raw readings near a realistic operating point, with some full-range noise.
  function automatic sample_t rand_sample();
    sample_t s;
    if ($urandom_range(0, 4) == 0) begin
      s.raw_temp = 16'($urandom);
      s.raw_pressure = 24'($urandom);
    end else begin
      s.raw_temp = 16'($urandom_range(20000, 32000));
      s.raw_pressure = 24'($urandom_range(20000, 30000) << 8) | 24'($urandom_range(0, 255));
    end
    return s;
  endfunction

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.raw_temp = '0;
    sample_ch.raw_pressure = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sh_ac12 = 0; sh_ac34 = 0; sh_ac56 = 0; sh_b12 = 0; sh_mcmd = 0;
    sh_oss = 0; sh_avg = 5'd1;
    win_count = 0; win_temp_sum = 0; win_pres_sum = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset coefficients: both compensation divisors are zero.
    pending_samples.push_back('{16'h0000, 24'h000000});
    pending_samples.push_back('{16'hFFFF, 24'hFFFFFF});
    wait_idle();

    // Directed: datasheet example point, field extremes, every oversampling.
    load_coefs(0);
    write_reg(REG_AVG_CNT, 32'd0);
    for (int o = 0; o < 4; o++) begin
      write_reg(REG_OSS, 32'(o));
      pending_samples.push_back('{16'd27898, 24'(23843 << 8)});
      pending_samples.push_back('{16'h0000, 24'h000000});
      pending_samples.push_back('{16'hFFFF, 24'hFFFFFF});
      pending_samples.push_back('{16'h5555, 24'hAAAAAA});
      pending_samples.push_back('{16'hAAAA, 24'h555555});
      wait_idle();
    end
    // Zero denominator in the temperature path: AC5 zero and MD zero.
    write_reg(REG_AC5_AC6, 32'h0000_1234);
    write_reg(REG_MC_MD, 32'hD4BD_0000);
    write_reg(REG_AVG_CNT, 32'd31);
    pending_samples.push_back('{16'd27898, 24'(23843 << 8)});
    pending_samples.push_back('{16'hFFFF, 24'h00FF00});
    wait_idle();
    // Extreme coefficients, saturating outputs.
    write_reg(REG_AC1_AC2, 32'h7FFF_8000);
    write_reg(REG_B1_B2, 32'h8000_7FFF);
    write_reg(REG_MC_MD, 32'h7FFF_0001);
    pending_samples.push_back('{16'h0000, 24'hFFFFFF});
    pending_samples.push_back('{16'hFFFF, 24'h000000});
    wait_idle();
    // Window shortened mid-window.
    write_reg(REG_AVG_CNT, 32'd2);
    pending_samples.push_back('{16'h8000, 24'h800000});
    wait_idle();

    // Random phases across averaging lengths and oversampling.
    for (int ph = 0; ph < 8; ph++) begin
      load_coefs(ph != 0);
      write_reg(REG_OSS, 32'($urandom_range(0, 3)));
      case (ph)
        0: write_reg(REG_AVG_CNT, 32'd1);
        1: write_reg(REG_AVG_CNT, 32'd16);
        2: write_reg(REG_AVG_CNT, 32'd17);
        default: write_reg(REG_AVG_CNT, 32'($urandom_range(0, 31)));
      endcase
      if (ph == 6) quiet_phase = 1;
      for (int k = 0; k < NUM_RANDOM / 8; k++) pending_samples.push_back(rand_sample());
      // Long hold-off on the result side while samples keep coming.
      if (ph == 3) begin
        long_hold = 1;
        repeat (2000) @(posedge clk);
        long_hold = 0;
      end
      wait_idle();
    end

    $display("%0d items accepted, %0d results checked, %0d windows closed, %0d divide errors",
             accepted, checked, windows, div_errors);
    if (errors == 0 && expected_results.size() == 0)
      $display("** baro_sensor_compensation_top: PASSED **");
    else
      $display("** baro_sensor_compensation_top: FAILED **");
    $finish;
  end

endmodule

[files.f]
src/bsc_pkg.sv
src/bsc_if.sv
src/baro_sensor_compensation_top.sv
sim/tb_top.sv
